FILE: rtl/pbw_pkg.sv
// Shared types, constants and helper functions for the packed bitmap pixel writer.
// Used by pbw_front, pbw_fifo, pbw_back and packed_bitmap_pixel_writer.
`timescale 1ns / 1ps

package pbw_pkg;

  localparam int ADDR_BITS  = 24;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int OUT_ADDR_W = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  // Queue depth between front and back, at least 2
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [31:0] FULL_MASK    = 32'hFFFF_FFFF;
  localparam logic [23:0] RGB_MASK     = 24'hFF_FFFF;
  localparam logic [4:0]  OFF_MASK     = 5'h1f;

  localparam logic OP_SET_POS = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  typedef enum logic [2:0] {
    MODE_1BPP      = 3'd0,
    MODE_2BPP      = 3'd1,
    MODE_4BPP      = 3'd2,
    MODE_8BPP      = 3'd3,
    MODE_16BPP     = 3'd4,
    MODE_24BPP     = 3'd5,
    MODE_32_OPAQUE = 3'd6,
    MODE_32_ALPHA  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_POS_OK  = 2'd1,
    KIND_POS_BAD = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_PITCH  = 3'd3,
    CFG_BASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [31:0]      pixel_value;
    logic             run_end;
  } pix_in_t;

  typedef struct packed {
    kind_e                 kind;
    logic [OUT_ADDR_W-1:0] word_address;
    logic [31:0]           write_data;
    logic [31:0]           write_mask;
    logic                  run_done;
    logic                  last;
  } pix_out_t;

  // Classified word handed from front to back
  typedef struct packed {
    kind_e                kind;
    logic [ADDR_BITS-1:0] addr;
    logic [4:0]           off;
    mode_e                mode;
    logic [31:0]          value;
    logic                 done;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // Value mask of the packed modes
  function automatic logic [31:0] pix_mask(input mode_e m);
    logic [31:0] r;
    case (m)
      MODE_1BPP:  r = 32'h0000_0001;
      MODE_2BPP:  r = 32'h0000_0003;
      MODE_4BPP:  r = 32'h0000_000F;
      MODE_8BPP:  r = 32'h0000_00FF;
      MODE_16BPP: r = 32'h0000_FFFF;
      default:    r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/pbw_front.sv
// Front end: configuration registers, position state and item classification.
// Depends on pbw_pkg; pushes one cmd_t word per accepted item into pbw_fifo.
`timescale 1ns / 1ps

module pbw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  pbw_pkg::pix_in_t               in_data_i,
  input  logic                           q_full_i,
  output logic                           in_stall_o,
  output logic                           push_o,
  output pbw_pkg::cmd_t                  cmd_o
);

  pbw_pkg::mode_e                   mode_q;
  logic [pbw_pkg::DIM_W-1:0]        width_q, height_q, pitch_q;
  logic [pbw_pkg::CFG_DATA_W-1:0]   base_q;

  logic [pbw_pkg::ADDR_BITS-1:0]    addr_q, addr_d;
  logic [4:0]                       off_q, off_d;
  logic [pbw_pkg::DIM_W-1:0]        col_q, col_d, row_q, row_d;

  logic [pbw_pkg::DIM_W-1:0]        clamp_w, clamp_h, col_inc;
  logic                             pos_bad, packed_mode;
  logic [2*pbw_pkg::DIM_W-2:0]      line_off;
  logic [pbw_pkg::POS_W-1:0]        x, y, x_words;
  logic [pbw_pkg::POS_W+4:0]        x_bits;
  logic [pbw_pkg::POS_W+1:0]        x_bytes;
  logic [4:0]                       new_off;
  logic [pbw_pkg::ADDR_BITS-1:0]    new_addr;
  logic [5:0]                       adv, off_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pbw_pkg::MODE_8BPP;
      width_q  <= pbw_pkg::DIM_W'(1);
      height_q <= pbw_pkg::DIM_W'(1);
      pitch_q  <= pbw_pkg::DIM_W'(1);
      base_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pbw_pkg::CFG_MODE:   mode_q   <= pbw_pkg::mode_e'(cfg_wdata_i[2:0]);
        pbw_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[pbw_pkg::DIM_W-1:0];
        pbw_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[pbw_pkg::DIM_W-1:0];
        pbw_pkg::CFG_PITCH:  pitch_q  <= cfg_wdata_i[pbw_pkg::DIM_W-1:0];
        pbw_pkg::CFG_BASE:   base_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign x          = in_data_i.pos_x;
  assign y          = in_data_i.pos_y;

  always_comb begin
    clamp_w     = pbw_pkg::clamp_dim(width_q);
    clamp_h     = pbw_pkg::clamp_dim(height_q);
    pos_bad     = ({1'b0, x} >= clamp_w) || ({1'b0, y} >= clamp_h);
    line_off    = (2*pbw_pkg::DIM_W-1)'(pitch_q) * (2*pbw_pkg::DIM_W-1)'(y);
    packed_mode = (mode_q <= pbw_pkg::MODE_16BPP);
    x_bits      = (pbw_pkg::POS_W+5)'(x) << mode_q;
    x_bytes     = {2'b00, x} + {1'b0, x, 1'b0};

    if (packed_mode) begin
      x_words = x >> (3'd5 - mode_q);
      new_off = x_bits[4:0];
    end else if (mode_q == pbw_pkg::MODE_24BPP) begin
      x_words = x_bytes[pbw_pkg::POS_W+1:2];
      new_off = {x_bytes[1:0], 3'b000};
    end else begin
      x_words = x;
      new_off = '0;
    end
    new_addr = pbw_pkg::ADDR_BITS'(base_q) + pbw_pkg::ADDR_BITS'(line_off)
             + pbw_pkg::ADDR_BITS'(x_words);

    // Bit advance of one pixel; whole-word modes step the address only
    if (packed_mode) begin
      adv = 6'd1 << mode_q;
    end else if (mode_q == pbw_pkg::MODE_24BPP) begin
      adv = 6'd24;
    end else begin
      adv = 6'd0;
    end
    off_sum = {1'b0, off_q} + adv;
    col_inc = col_q + pbw_pkg::DIM_W'(1);

    addr_d = addr_q;
    off_d  = off_q;
    col_d  = col_q;
    row_d  = row_q;

    cmd_o.kind  = pbw_pkg::KIND_WRITE;
    cmd_o.addr  = addr_q;
    cmd_o.off   = off_q;
    cmd_o.mode  = mode_q;
    cmd_o.value = in_data_i.pixel_value;
    cmd_o.done  = in_data_i.run_end;

    if (in_data_i.operation == pbw_pkg::OP_SET_POS) begin
      cmd_o.off = '0;
      if (pos_bad) begin
        cmd_o.kind = pbw_pkg::KIND_POS_BAD;
        cmd_o.addr = '0;
      end else begin
        cmd_o.kind = pbw_pkg::KIND_POS_OK;
        cmd_o.addr = new_addr;
        addr_d     = new_addr;
        off_d      = new_off;
        col_d      = {1'b0, x};
        row_d      = {1'b0, y};
      end
    end else begin
      if (packed_mode || mode_q == pbw_pkg::MODE_24BPP) begin
        addr_d = addr_q + pbw_pkg::ADDR_BITS'(off_sum[5]);
        off_d  = off_sum[4:0] & pbw_pkg::OFF_MASK;
      end else begin
        addr_d = addr_q + pbw_pkg::ADDR_BITS'(1);
      end
      // Wrap to the next row at the width
      if (col_inc >= clamp_w) begin
        col_d = '0;
        row_d = row_q + pbw_pkg::DIM_W'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      off_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (push_o) begin
      addr_q <= addr_d;
      off_q  <= off_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

FILE: rtl/pbw_fifo.sv
// Short queue of classified words between the front and the back end.
// Depends on pbw_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module pbw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbw_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output pbw_pkg::cmd_t head_o
);

  pbw_pkg::cmd_t              mem_q [pbw_pkg::Q_DEPTH];
  logic [pbw_pkg::Q_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pbw_pkg::Q_AW:0]     count_q, count_d;

  assign full_o  = (count_q == (pbw_pkg::Q_AW+1)'(pbw_pkg::Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pbw_pkg::Q_AW'(pbw_pkg::Q_DEPTH-1)) ? '0
               : wr_ptr_q + pbw_pkg::Q_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pbw_pkg::Q_AW'(pbw_pkg::Q_DEPTH-1)) ? '0
               : rd_ptr_q + pbw_pkg::Q_AW'(1);
    end
    count_d = count_q + (pbw_pkg::Q_AW+1)'(push_i) - (pbw_pkg::Q_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (pbw_pkg::Q_AW+1)'(pbw_pkg::Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: rtl/pbw_back.sv
// Back end: turns queued words into masked write words and position reports.
// Depends on pbw_pkg; a straddling 24-bit pixel is split into two output words.
`timescale 1ns / 1ps

module pbw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  pbw_pkg::cmd_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pbw_pkg::pix_out_t out_data_o
);

  logic              out_vld_q, out_vld_d;
  pbw_pkg::pix_out_t out_q, out_d;
  logic              half2_q, half2_d;
  pbw_pkg::cmd_t     hold_q;

  logic              can_load, straddle;
  logic [31:0]       pm, rgb;
  logic [5:0]        hi_shift;
  pbw_pkg::pix_out_t first_w, second_w;

  assign can_load    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    // First (or only) word of the head entry
    pm       = pbw_pkg::pix_mask(head_i.mode);
    rgb      = 32'(head_i.value[23:0]);
    straddle = (head_i.kind == pbw_pkg::KIND_WRITE)
            && (head_i.mode == pbw_pkg::MODE_24BPP) && (head_i.off > 5'd8);

    first_w.kind         = head_i.kind;
    first_w.word_address = pbw_pkg::OUT_ADDR_W'(head_i.addr);
    first_w.write_data   = '0;
    first_w.write_mask   = '0;
    first_w.run_done     = head_i.done;
    first_w.last         = 1'b1;
    if (head_i.kind == pbw_pkg::KIND_WRITE) begin
      case (head_i.mode)
        pbw_pkg::MODE_24BPP: begin
          first_w.write_data = rgb << head_i.off;
          if (straddle) begin
            first_w.write_mask = pbw_pkg::FULL_MASK << head_i.off;
            first_w.run_done   = 1'b0;
            first_w.last       = 1'b0;
          end else begin
            first_w.write_mask = 32'(pbw_pkg::RGB_MASK) << head_i.off;
          end
        end
        pbw_pkg::MODE_32_OPAQUE: begin
          first_w.write_data = head_i.value | pbw_pkg::ALPHA_OPAQUE;
          first_w.write_mask = pbw_pkg::FULL_MASK;
        end
        pbw_pkg::MODE_32_ALPHA: begin
          first_w.write_data = head_i.value;
          first_w.write_mask = pbw_pkg::FULL_MASK;
        end
        default: begin
          first_w.write_data = (head_i.value & pm) << head_i.off;
          first_w.write_mask = pm << head_i.off;
        end
      endcase
    end

    // High part of a straddling pixel goes into the next word
    hi_shift                = 6'd32 - {1'b0, hold_q.off};
    second_w.kind           = pbw_pkg::KIND_WRITE;
    second_w.word_address   = pbw_pkg::OUT_ADDR_W'(hold_q.addr + pbw_pkg::ADDR_BITS'(1));
    second_w.write_data     = 32'(hold_q.value[23:0]) >> hi_shift;
    second_w.write_mask     = 32'(pbw_pkg::RGB_MASK) >> hi_shift;
    second_w.run_done       = hold_q.done;
    second_w.last           = 1'b1;

    pop_o     = 1'b0;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    half2_d   = half2_q;
    if (can_load) begin
      if (half2_q) begin
        out_vld_d = 1'b1;
        out_d     = second_w;
        half2_d   = 1'b0;
      end else if (!q_empty_i) begin
        pop_o     = 1'b1;
        out_vld_d = 1'b1;
        out_d     = first_w;
        half2_d   = straddle;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      half2_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      half2_q   <= half2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) begin
      hold_q <= head_i;
    end
  end

`ifndef SYNTHESIS
  a_half2_is_24bpp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half2_q |-> (hold_q.mode == pbw_pkg::MODE_24BPP) && (hold_q.kind == pbw_pkg::KIND_WRITE))
    else $error("second half pending for a non-straddling word");
  a_first_half_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.last) |-> half2_q)
    else $error("low part shown without high part pending");
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && !out_q.last) |=> (out_vld_q && out_q.last))
    else $error("high part of straddling pixel did not follow");
`endif

endmodule

FILE: rtl/packed_bitmap_pixel_writer.sv
// Top level of the packed bitmap pixel writer: front end, queue and back end.
// Depends on pbw_pkg, pbw_front, pbw_fifo and pbw_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   input    | in_valid_i / in_stall_o   | in_data_i  (pbw_pkg::pix_in_t)
//   output   | out_valid_o / out_stall_i | out_data_o (pbw_pkg::pix_out_t)
//   config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One input word per cycle while the queue is not full; a straddling 24-bit pixel
// gives two output words, all others give one. Each item passes through the 4-entry
// queue register, then the output register. Position math uses one 13x12 multiplier.
// Reset clears position state, the queue and the output valid flag, and loads
// the configuration reset values. Input stalls only while the queue is full.
`timescale 1ns / 1ps

module packed_bitmap_pixel_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pbw_pkg::pix_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pbw_pkg::pix_out_t              out_data_o
);

  logic          push, pop, q_full, q_empty;
  pbw_pkg::cmd_t push_cmd, head_cmd;

  pbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  pbw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  pbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
